// File: rtl/rhw_pkg.sv
// Shared constants, types and tables for the hue wheel pixel unit.
package rhw_pkg;

    localparam int ITERS       = 18;
    localparam int ZW          = 22;
    localparam int THIRD_TURN  = 21845;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        t_REG_CENTER_X = 1'b0,
        t_REG_CENTER_Y = 1'b1
    } t_reg_idx;

    function automatic logic [ZW-1:0] atan_step(input logic [4:0] i);
        logic [ZW-1:0] r;
        begin
            case (i)
                5'd0:  r = ZW'(131072);
                5'd1:  r = ZW'(77376);
                5'd2:  r = ZW'(40884);
                5'd3:  r = ZW'(20753);
                5'd4:  r = ZW'(10417);
                5'd5:  r = ZW'(5213);
                5'd6:  r = ZW'(2607);
                5'd7:  r = ZW'(1304);
                5'd8:  r = ZW'(652);
                5'd9:  r = ZW'(326);
                5'd10: r = ZW'(163);
                5'd11: r = ZW'(81);
                5'd12: r = ZW'(41);
                5'd13: r = ZW'(20);
                5'd14: r = ZW'(10);
                5'd15: r = ZW'(5);
                5'd16: r = ZW'(3);
                5'd17: r = ZW'(1);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [16:0] cos_entry(input logic [4:0] k);
        logic [16:0] r;
        begin
            case (k)
                5'd0:  r = 17'd65536;
                5'd1:  r = 17'd65220;
                5'd2:  r = 17'd64277;
                5'd3:  r = 17'd62714;
                5'd4:  r = 17'd60547;
                5'd5:  r = 17'd57798;
                5'd6:  r = 17'd54491;
                5'd7:  r = 17'd50660;
                5'd8:  r = 17'd46341;
                5'd9:  r = 17'd41576;
                5'd10: r = 17'd36410;
                5'd11: r = 17'd30893;
                5'd12: r = 17'd25080;
                5'd13: r = 17'd19024;
                5'd14: r = 17'd12785;
                5'd15: r = 17'd6424;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/rhw_stream_if.sv
// Valid/ready stream interface.
interface rhw_stream_if #(parameter int W = 20);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rhw_cordic_stage.sv
// One vectoring CORDIC iteration with its pipeline register.
module rhw_cordic_stage import rhw_pkg::*; #(
    parameter int VW    = 32,
    parameter int SHIFT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [VW-1:0] i_x,
    input  logic signed [VW-1:0] i_y,
    input  logic [ZW-1:0]        i_z,
    output logic                 o_valid,
    output logic signed [VW-1:0] o_x,
    output logic signed [VW-1:0] o_y,
    output logic [ZW-1:0]        o_z
);
    logic                 r_valid;
    logic signed [VW-1:0] r_x, r_y, n_x, n_y;
    logic [ZW-1:0]        r_z, n_z;

    always_comb begin
        if (i_y > 0) begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + atan_step(5'(SHIFT));
        end else begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - atan_step(5'(SHIFT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
endmodule

// File: rtl/rhw_channel.sv
// Angle to channel intensity: folded cosine table, interpolation, scaling; two stages.
module rhw_channel import rhw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_angle,
    output logic [7:0]  o_level
);
    logic [15:0] a1;
    logic [14:0] a2;
    logic        neg;
    logic [4:0]  idx;
    logic [9:0]  frac;
    logic [16:0] c0, c1;

    logic [16:0] r_c0;
    logic [16:0] r_diff;
    logic [9:0]  r_frac;
    logic        r_neg, r_zero;

    logic [26:0] prod;
    logic [16:0] mag;
    logic [17:0] s;
    logic [25:0] scaled;

    always_comb begin
        a1 = (i_angle > 16'd32768) ? 16'(17'd65536 - {1'b0, i_angle}) : i_angle;
        if (a1 > 16'd16384) begin
            a2  = 15'(16'd32768 - a1);
            neg = 1'b1;
        end else begin
            a2  = a1[14:0];
            neg = 1'b0;
        end
        idx  = a2[14:10];
        frac = a2[9:0];
        c0   = cos_entry(idx);
        c1   = cos_entry(5'(idx + 5'd1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0   <= c0;
            r_diff <= c0 - c1;
            r_frac <= frac;
            r_neg  <= neg;
            r_zero <= idx[4];
        end
    end

    always_comb begin
        prod = 27'(r_diff) * 27'(r_frac) + 27'd512;
        mag  = r_zero ? 17'd0 : 17'(r_c0 - 17'(prod >> 10));
        s    = r_neg ? 18'(18'd65536 - {1'b0, mag}) : 18'(18'd65536 + {1'b0, mag});
        scaled = 26'(s) * 26'd255;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_level <= scaled[24:17];
        end
    end
endmodule

// File: rtl/radial_hue_wheel_pixel_unit.sv
// Top level of the hue wheel pixel unit.
// Hue wheel pixel unit: a pixel (x, y) enters each cycle that the pipeline advances and its RGB color
// leaves after 1 offset stage, 18 CORDIC stages, 1 rounding stage and 2 color stages.
// One beat per clock sustained while the output is not stalled; the whole pipeline advances together
// and holds when the output is stalled. Write center_x (index 0) and center_y (index 1)
// only while no pixel is in flight; values at or above COORD_RANGE clamp.
module radial_hue_wheel_pixel_unit import rhw_pkg::*; #(
    parameter int COORD_RANGE = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rhw_stream_if.sink            s_pix,
    rhw_stream_if.source          m_rgb
);
    localparam int CW = $clog2(COORD_RANGE);
    localparam int VW = CW + 20 + 3;
    localparam logic [CW-1:0] MAXC = CW'(COORD_RANGE - 1);

    logic [CW-1:0] r_cx, r_cy;
    logic          adv;

    function automatic logic [CW-1:0] clampc(input logic [9:0] v);
        return (32'(v) >= 32'(COORD_RANGE)) ? MAXC : CW'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= CW'(COORD_RANGE / 2);
            r_cy <= CW'(COORD_RANGE / 2);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                t_REG_CENTER_X: r_cx <= clampc(i_cfg_data);
                t_REG_CENTER_Y: r_cy <= clampc(i_cfg_data);
                default: ;
            endcase
        end
    end

    // All stages advance when the output register is empty or being drained.
    logic       r_ov;
    logic [7:0] ch_r, ch_g, ch_b;
    assign adv         = !r_ov || m_rgb.ready;
    assign s_pix.ready = adv;

    // Offset and half-plane fold
    logic                 r_v0, r_zero0;
    logic signed [VW-1:0] r_x0, r_y0;
    logic [ZW-1:0]        r_z0;
    logic signed [CW:0]   dx, dy;

    always_comb begin
        dx = $signed({1'b0, clampc(s_pix.data[9:0])}) - $signed({1'b0, r_cx});
        dy = $signed({1'b0, clampc(s_pix.data[19:10])}) - $signed({1'b0, r_cy});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (adv) r_v0 <= s_pix.valid;
        if (adv) begin
            r_zero0 <= (dx == 0) && (dy == 0);
            if (dx < 0) begin
                r_x0 <= VW'(-dx) <<< 20;
                r_y0 <= VW'(-dy) <<< 20;
                r_z0 <= ZW'(524288);
            end else begin
                r_x0 <= VW'(dx) <<< 20;
                r_y0 <= VW'(dy) <<< 20;
                r_z0 <= '0;
            end
        end
    end

    logic                 v [ITERS+1];
    logic signed [VW-1:0] xs [ITERS+1];
    logic signed [VW-1:0] ys [ITERS+1];
    logic [ZW-1:0]        zs [ITERS+1];
    logic [ITERS:0]       zero_line;

    assign v[0]  = r_v0;
    assign xs[0] = r_x0;
    assign ys[0] = r_y0;
    assign zs[0] = r_z0;
    assign zero_line[0] = r_zero0;

    for (genvar g = 0; g < ITERS; g++) begin : g_cordic
        rhw_cordic_stage #(.VW(VW), .SHIFT(g)) u_stage (
            .i_clk, .i_rst_n, .i_en(adv),
            .i_valid(v[g]), .i_x(xs[g]), .i_y(ys[g]), .i_z(zs[g]),
            .o_valid(v[g+1]), .o_x(xs[g+1]), .o_y(ys[g+1]), .o_z(zs[g+1])
        );
        logic r_zl;
        always_ff @(posedge i_clk) if (adv) r_zl <= zero_line[g];
        assign zero_line[g+1] = r_zl;
    end

    // Angle rounding and color phases
    logic        r_va;
    logic [15:0] r_th, r_thg, r_thb;
    logic [15:0] th;
    assign th = zero_line[ITERS] ? 16'd0 : 16'((zs[ITERS] + ZW'(8)) >> 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (adv) r_va <= v[ITERS];
        if (adv) begin
            r_th  <= th;
            r_thg <= 16'(th + 16'(THIRD_TURN));
            r_thb <= 16'(th - 16'(THIRD_TURN));
        end
    end

    rhw_channel u_red   (.i_clk, .i_en(adv), .i_angle(r_th),  .o_level(ch_r));
    rhw_channel u_green (.i_clk, .i_en(adv), .i_angle(r_thg), .o_level(ch_g));
    rhw_channel u_blue  (.i_clk, .i_en(adv), .i_angle(r_thb), .o_level(ch_b));

    // Valid bits for the two color stages
    logic r_vc1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc1 <= 1'b0;
            r_ov  <= 1'b0;
        end else if (adv) begin
            r_vc1 <= r_va;
            r_ov  <= r_vc1;
        end
    end

    // Channel modules' output registers are the final stage; they hold while stalled.
    assign m_rgb.valid = r_ov;
    assign m_rgb.data  = {ch_b, ch_g, ch_r};
endmodule
